>>> rtl/skinp_pkg.sv
// Shared types and fixed-point constants of the skin likelihood pipeline.
package skinp_pkg;

   localparam int EXP_TABLE_DEPTH = 256;

   localparam int CHAN_W  = 8;
   localparam int CSR_W   = 16;
   localparam int INDEX_W = 3;
   localparam int CHROMA_W = 18;
   localparam int LIKE_W  = 8;

   localparam logic [19:0] COEF_YR = 20'd313524;
   localparam logic [19:0] COEF_YG = 20'd615514;
   localparam logic [19:0] COEF_YB = 20'd119538;
   localparam logic [19:0] COEF_U  = 20'd515899;
   localparam logic [19:0] COEF_V  = 20'd919601;

   localparam logic [INDEX_W-1:0] CSR_MEAN_CB    = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_MEAN_CR    = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_INV_COV_BB = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_INV_COV_BR = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_INV_COV_RR = 3'd4;
   localparam logic [INDEX_W-1:0] CSR_BLUE_FIRST = 3'd5;

   localparam logic [15:0] RESET_MEAN_CB    = 16'd30062;
   localparam logic [15:0] RESET_MEAN_CR    = 16'd38031;
   localparam logic [15:0] RESET_INV_COV_BB = 16'd11290;
   localparam logic [15:0] RESET_INV_COV_BR = 16'hF866;
   localparam logic [15:0] RESET_INV_COV_RR = 16'd7720;

   typedef struct packed {
      logic [15:0]        mean_cb;
      logic [15:0]        mean_cr;
      logic [15:0]        inv_cov_bb;
      logic signed [15:0] inv_cov_br;
      logic [15:0]        inv_cov_rr;
      logic               blue_first;
   } cfg_type;

endpackage

>>> rtl/skinp_color.sv
// Color conversion stages: luma, then the two chroma values in signed Q.8.
module skinp_color (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [skinp_pkg::CHAN_W-1:0]        chan_zero,
   input  logic [skinp_pkg::CHAN_W-1:0]        chan_one,
   input  logic [skinp_pkg::CHAN_W-1:0]        chan_two,
   input  skinp_pkg::cfg_type                  cfg,
   output logic                                out_valid,
   output logic signed [skinp_pkg::CHROMA_W-1:0] out_u,
   output logic signed [skinp_pkg::CHROMA_W-1:0] out_v
);

   logic [7:0]  red, blue;
   logic [28:0] y20;
   logic [16:0] a_y8_in;

   logic        a_valid_ff;
   logic [16:0] a_y8_ff;
   logic [7:0]  a_red_ff, a_blue_ff;

   logic signed [17:0] diff_b, diff_r;
   logic signed [39:0] sum_u, sum_v;
   logic signed [39:0] shift_u, shift_v;
   logic signed [17:0] b_u_in, b_v_in;

   logic               b_valid_ff;
   logic signed [17:0] b_u_ff, b_v_ff;

   assign red  = cfg.blue_first ? chan_two : chan_zero;
   assign blue = cfg.blue_first ? chan_zero : chan_two;

   assign y20 = 29'(skinp_pkg::COEF_YR) * 29'(red)
              + 29'(skinp_pkg::COEF_YG) * 29'(chan_one)
              + 29'(skinp_pkg::COEF_YB) * 29'(blue)
              + (29'd16 << 20);
   assign a_y8_in = 17'((y20 + 29'd2048) >> 12);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_y8_ff   <= a_y8_in;
         a_red_ff  <= red;
         a_blue_ff <= blue;
      end
   end

   assign diff_b = $signed({2'b00, a_blue_ff, 8'h00}) - $signed({1'b0, a_y8_ff});
   assign diff_r = $signed({2'b00, a_red_ff, 8'h00}) - $signed({1'b0, a_y8_ff});

   assign sum_u = 40'($signed({1'b0, skinp_pkg::COEF_U}) * diff_b)
                + (40'sd1 <<< 35) + (40'sd1 <<< 19);
   assign sum_v = 40'($signed({1'b0, skinp_pkg::COEF_V}) * diff_r)
                + (40'sd1 <<< 35) + (40'sd1 <<< 19);

   assign shift_u = sum_u >>> 20;
   assign shift_v = sum_v >>> 20;
   assign b_u_in  = shift_u[17:0];
   assign b_v_in  = shift_v[17:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_u_ff <= b_u_in;
         b_v_ff <= b_v_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_u     = b_u_ff;
   assign out_v     = b_v_ff;

endmodule

>>> rtl/skinp_form.sv
// Quadratic form stages: offsets from the mean, squares, weighting and the final sum.
module skinp_form (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [skinp_pkg::CHROMA_W-1:0] in_u,
   input  logic signed [skinp_pkg::CHROMA_W-1:0] in_v,
   input  skinp_pkg::cfg_type                    cfg,
   output logic                                  out_valid,
   output logic                                  out_neg,
   output logic                                  out_over,
   output logic [39:0]                           out_dist
);

   logic signed [18:0] t0_wide, t1_wide;
   logic signed [17:0] t0, t1;
   logic signed [35:0] c_p00_in, c_p01_in, c_p11_in;

   logic               c_valid_ff;
   logic signed [35:0] c_p00_ff, c_p01_ff, c_p11_ff;

   logic signed [52:0] d_bb_in, d_br_in, d_rr_in;

   logic               d_valid_ff;
   logic signed [52:0] d_bb_ff, d_br_ff, d_rr_ff;

   logic signed [54:0] form_sum;

   logic               e_valid_ff;
   logic               e_neg_ff, e_over_ff;
   logic [39:0]        e_dist_ff;

   assign t0_wide = 19'(in_u) - $signed({3'b000, cfg.mean_cb});
   assign t1_wide = 19'(in_v) - $signed({3'b000, cfg.mean_cr});
   assign t0 = t0_wide[17:0];
   assign t1 = t1_wide[17:0];

   assign c_p00_in = t0 * t0;
   assign c_p01_in = t0 * t1;
   assign c_p11_in = t1 * t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= in_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_p00_ff <= c_p00_in;
         c_p01_ff <= c_p01_in;
         c_p11_ff <= c_p11_in;
      end
   end

   assign d_bb_in = $signed({1'b0, cfg.inv_cov_bb}) * c_p00_ff;
   assign d_br_in = 53'(cfg.inv_cov_br * c_p01_ff) <<< 1;
   assign d_rr_in = $signed({1'b0, cfg.inv_cov_rr}) * c_p11_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d_bb_ff <= d_bb_in;
         d_br_ff <= d_br_in;
         d_rr_ff <= d_rr_in;
      end
   end

   assign form_sum = 55'(d_bb_ff) + 55'(d_br_ff) + 55'(d_rr_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         e_neg_ff  <= form_sum[54];
         e_over_ff <= !form_sum[54] && (form_sum[54:40] != 15'd0);
         e_dist_ff <= form_sum[39:0];
      end
   end

   assign out_valid = e_valid_ff;
   assign out_neg   = e_neg_ff;
   assign out_over  = e_over_ff;
   assign out_dist  = e_dist_ff;

endmodule

>>> rtl/skinp_expo.sv
// Table index scaling and the exponential lookup that drives the output word.
module skinp_expo #(
   parameter int EXP_TABLE_DEPTH = skinp_pkg::EXP_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic                              in_neg,
   input  logic                              in_over,
   input  logic [39:0]                       in_dist,
   output logic                              out_valid,
   output logic [skinp_pkg::LIKE_W-1:0]      out_likelihood
);

   localparam int AW = $clog2(EXP_TABLE_DEPTH);
   localparam int IW = AW + 1;
   localparam int PW = 40 + IW;

   typedef logic [7:0] table_type [EXP_TABLE_DEPTH];

   function automatic longint div_step(input longint t, input int k);
      case (k)
         2:       return t / 2;
         3:       return t / 3;
         4:       return t / 4;
         5:       return t / 5;
         6:       return t / 6;
         7:       return t / 7;
         8:       return t / 8;
         9:       return t / 9;
         10:      return t / 10;
         11:      return t / 11;
         12:      return t / 12;
         default: return t;
      endcase
   endfunction

   function automatic table_type build_table();
      table_type tbl;
      longint    x;
      longint    term;
      longint    ratio;
      longint    v;
      longint    e;
      x     = (longint'(8) << 31) / EXP_TABLE_DEPTH;
      term  = longint'(1) << 31;
      ratio = longint'(1) << 31;
      v     = longint'(1) << 31;
      for (int k = 1; k <= 12; k++) begin
         term = (term * x) >>> 31;
         term = div_step(term, k);
         if ((k % 2) == 1) begin
            ratio = ratio - term;
         end else begin
            ratio = ratio + term;
         end
      end
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
         e = (255 * v + (longint'(1) << 30)) >>> 31;
         if (e > 255) begin
            e = 255;
         end
         if (e < 0) begin
            e = 0;
         end
         tbl[i] = 8'(e);
         v = (v * ratio + (longint'(1) << 30)) >>> 31;
      end
      return tbl;
   endfunction

   localparam table_type EXP_TABLE = build_table();

   logic [PW-1:0] scaled;
   logic [IW-1:0] index;
   logic          beyond;

   logic          f_valid_ff;
   logic          f_neg_ff, f_zero_ff;
   logic [AW-1:0] f_addr_ff;

   logic                         g_valid_ff;
   logic [skinp_pkg::LIKE_W-1:0] g_likelihood_in;
   logic [skinp_pkg::LIKE_W-1:0] g_likelihood_ff;

   assign scaled = PW'(in_dist) * PW'(EXP_TABLE_DEPTH) + (PW'(1) << 39);
   assign index  = scaled[PW-1:40];
   assign beyond = in_over || (index >= IW'(EXP_TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= in_valid;
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_neg_ff  <= in_neg;
         f_zero_ff <= beyond;
         f_addr_ff <= beyond ? '0 : index[AW-1:0];
      end
   end

   always_comb begin
      if (f_neg_ff) begin
         g_likelihood_in = 8'd255;
      end else if (f_zero_ff) begin
         g_likelihood_in = 8'd0;
      end else begin
         g_likelihood_in = EXP_TABLE[f_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_likelihood_ff <= g_likelihood_in;
      end
   end

   assign out_valid      = g_valid_ff;
   assign out_likelihood = g_likelihood_ff;

endmodule

>>> rtl/skin_probability_ycbcr.sv
// Top level of the skin likelihood block: register file and pipeline wiring.
//
// A pixel word enters on the req_ channel (req_valid/req_ready) with three
// 8-bit channels, green in the middle; blue_first selects whether the first
// channel is red or blue. Each word yields exactly one 8-bit likelihood word
// on the rsp_ channel (rsp_valid/rsp_ready).
// The pipeline has seven register stages: luma, chroma, mean offsets and
// squares, covariance weighting, form sum, table index, and the table read
// into the output register. One word is taken every cycle while the receiver
// keeps up. When the receiver stalls with a result waiting, the whole
// pipeline holds and req_ready drops in the same cycle, so nothing is lost
// or repeated. Configuration registers are written through csr_we,
// csr_index and csr_wdata, one register per cycle, and should change only
// while no word is in flight. Reset empties the pipeline and loads the
// default mean and inverse covariance values with red as the first channel.
module skin_probability_ycbcr #(
   parameter int EXP_TABLE_DEPTH = skinp_pkg::EXP_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [skinp_pkg::CHAN_W-1:0]       req_chan_zero,
   input  logic [skinp_pkg::CHAN_W-1:0]       req_chan_one,
   input  logic [skinp_pkg::CHAN_W-1:0]       req_chan_two,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [skinp_pkg::LIKE_W-1:0]       rsp_likelihood,
   input  logic                               csr_we,
   input  logic [skinp_pkg::INDEX_W-1:0]      csr_index,
   input  logic [skinp_pkg::CSR_W-1:0]        csr_wdata
);

   skinp_pkg::cfg_type cfg_ff;

   logic en;

   logic                                  chroma_valid;
   logic signed [skinp_pkg::CHROMA_W-1:0] chroma_u, chroma_v;

   logic        form_valid;
   logic        form_neg, form_over;
   logic [39:0] form_dist;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mean_cb    <= skinp_pkg::RESET_MEAN_CB;
         cfg_ff.mean_cr    <= skinp_pkg::RESET_MEAN_CR;
         cfg_ff.inv_cov_bb <= skinp_pkg::RESET_INV_COV_BB;
         cfg_ff.inv_cov_br <= skinp_pkg::RESET_INV_COV_BR;
         cfg_ff.inv_cov_rr <= skinp_pkg::RESET_INV_COV_RR;
         cfg_ff.blue_first <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            skinp_pkg::CSR_MEAN_CB:    cfg_ff.mean_cb    <= csr_wdata;
            skinp_pkg::CSR_MEAN_CR:    cfg_ff.mean_cr    <= csr_wdata;
            skinp_pkg::CSR_INV_COV_BB: cfg_ff.inv_cov_bb <= csr_wdata;
            skinp_pkg::CSR_INV_COV_BR: cfg_ff.inv_cov_br <= csr_wdata;
            skinp_pkg::CSR_INV_COV_RR: cfg_ff.inv_cov_rr <= csr_wdata;
            skinp_pkg::CSR_BLUE_FIRST: cfg_ff.blue_first <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   skinp_color u_color (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .chan_zero (req_chan_zero),
      .chan_one  (req_chan_one),
      .chan_two  (req_chan_two),
      .cfg       (cfg_ff),
      .out_valid (chroma_valid),
      .out_u     (chroma_u),
      .out_v     (chroma_v)
   );

   skinp_form u_form (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (chroma_valid),
      .in_u      (chroma_u),
      .in_v      (chroma_v),
      .cfg       (cfg_ff),
      .out_valid (form_valid),
      .out_neg   (form_neg),
      .out_over  (form_over),
      .out_dist  (form_dist)
   );

   skinp_expo #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_expo (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (form_valid),
      .in_neg         (form_neg),
      .in_over        (form_over),
      .in_dist        (form_dist),
      .out_valid      (rsp_valid),
      .out_likelihood (rsp_likelihood)
   );

endmodule

>>> verif/skin_probability_ycbcr_test.sv
// Self-checking testbench of the skin likelihood block: directed and random pixel words.
module skin_probability_ycbcr_test;

   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_WAIT = 17;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_WORDS = 200;
   localparam int DIRECTED_ROWS = 22;
   localparam int SETTING_COUNT = 5;
   localparam logic [skinp_pkg::INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [skinp_pkg::INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [1:0] {CFG_NEAR_DEFAULT, CFG_TIGHT, CFG_ANY, CFG_CORNER} cfg_kind_type;

   typedef struct packed {
      logic [2:0] setting;
      logic [7:0] chan_zero;
      logic [7:0] chan_one;
      logic [7:0] chan_two;
      logic       typed;
      logic [7:0] want;
   } pixel_row_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [skinp_pkg::CHAN_W-1:0]   req_chan_zero;
   logic [skinp_pkg::CHAN_W-1:0]   req_chan_one;
   logic [skinp_pkg::CHAN_W-1:0]   req_chan_two;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [skinp_pkg::LIKE_W-1:0]   rsp_likelihood;
   logic                           csr_we;
   logic [skinp_pkg::INDEX_W-1:0]  csr_index;
   logic [skinp_pkg::CSR_W-1:0]    csr_wdata;

   logic                row_typed;
   logic [7:0]          row_want;
   bit                  sender_eager;
   bit                  receiver_eager;

   logic [7:0]          exp_table [skinp_pkg::EXP_TABLE_DEPTH];
   skinp_pkg::cfg_type  model_cfg;
   logic [7:0]          likelihood_due [$];
   int                  stall_left;
   int                  error_count;
   int                  pixels_sent;
   int                  results_seen;
   int                  settings_applied;

   pixel_row_type       directed_rows [DIRECTED_ROWS];
   skinp_pkg::cfg_type  directed_cfg [SETTING_COUNT];

   skin_probability_ycbcr dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_chan_zero  (req_chan_zero),
      .req_chan_one   (req_chan_one),
      .req_chan_two   (req_chan_two),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_likelihood (rsp_likelihood),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [7:0] likelihood_of(input skinp_pkg::cfg_type c,
                                                input logic [7:0] c0,
                                                input logic [7:0] c1, input logic [7:0] c2);
      longint red, grn, blu, y20, y8, u8, v8, t0, t1, d, idx;
      grn = longint'(c1);
      if (c.blue_first) begin
         blu = longint'(c0);
         red = longint'(c2);
      end else begin
         red = longint'(c0);
         blu = longint'(c2);
      end
      y20 = longint'(skinp_pkg::COEF_YR) * red + longint'(skinp_pkg::COEF_YG) * grn
          + longint'(skinp_pkg::COEF_YB) * blu + (64'sd16 <<< 20);
      y8 = (y20 + (64'sd1 <<< 11)) >>> 12;
      u8 = (longint'(skinp_pkg::COEF_U) * (blu * 256 - y8) + (64'sd128 <<< 28)
            + (64'sd1 <<< 19)) >>> 20;
      v8 = (longint'(skinp_pkg::COEF_V) * (red * 256 - y8) + (64'sd128 <<< 28)
            + (64'sd1 <<< 19)) >>> 20;
      t0 = u8 - longint'(c.mean_cb);
      t1 = v8 - longint'(c.mean_cr);
      d = longint'(c.inv_cov_bb) * t0 * t0 + 2 * longint'(c.inv_cov_br) * t0 * t1
        + longint'(c.inv_cov_rr) * t1 * t1;
      if (d < 0) return 8'd255;
      if (d >= (64'sd16 <<< 36)) return 8'd0;
      idx = (d * skinp_pkg::EXP_TABLE_DEPTH + (64'sd1 <<< 39)) >>> 40;
      if (idx >= skinp_pkg::EXP_TABLE_DEPTH) return 8'd0;
      return exp_table[idx];
   endfunction

   task automatic csr_write(input logic [skinp_pkg::INDEX_W-1:0] idx,
                            input logic [skinp_pkg::CSR_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_cfg(input skinp_pkg::cfg_type c);
      csr_write(skinp_pkg::CSR_MEAN_CB, c.mean_cb);
      csr_write(skinp_pkg::CSR_MEAN_CR, c.mean_cr);
      csr_write(skinp_pkg::CSR_INV_COV_BB, c.inv_cov_bb);
      csr_write(skinp_pkg::CSR_INV_COV_BR, c.inv_cov_br);
      csr_write(skinp_pkg::CSR_INV_COV_RR, c.inv_cov_rr);
      csr_write(skinp_pkg::CSR_BLUE_FIRST, {15'($urandom), c.blue_first});
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (results_seen < pixels_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
                             input logic typed, input logic [7:0] want);
      int unsigned gap;
      gap = sender_eager ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_chan_zero <= c0;
      req_chan_one <= c1;
      req_chan_two <= c2;
      row_typed <= typed;
      row_want <= want;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   always @(posedge clock) begin : scoreboard
      logic [7:0]  want;
      int unsigned stall;
      if (reset) begin
         model_cfg = '{skinp_pkg::RESET_MEAN_CB, skinp_pkg::RESET_MEAN_CR,
                       skinp_pkg::RESET_INV_COV_BB, skinp_pkg::RESET_INV_COV_BR,
                       skinp_pkg::RESET_INV_COV_RR, 1'b0};
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               skinp_pkg::CSR_MEAN_CB:    model_cfg.mean_cb = csr_wdata;
               skinp_pkg::CSR_MEAN_CR:    model_cfg.mean_cr = csr_wdata;
               skinp_pkg::CSR_INV_COV_BB: model_cfg.inv_cov_bb = csr_wdata;
               skinp_pkg::CSR_INV_COV_BR: model_cfg.inv_cov_br = csr_wdata;
               skinp_pkg::CSR_INV_COV_RR: model_cfg.inv_cov_rr = csr_wdata;
               skinp_pkg::CSR_BLUE_FIRST: model_cfg.blue_first = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            likelihood_due.push_back(row_typed ? row_want :
               likelihood_of(model_cfg, req_chan_zero, req_chan_one, req_chan_two));
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (likelihood_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected likelihood word, expected none, got %0d",
                        $time, rsp_likelihood);
            end else begin
               want = likelihood_due.pop_front();
               if (rsp_likelihood !== want) begin
                  error_count++;
                  $display("%0t: likelihood mismatch, expected %0d, got %0d",
                           $time, want, rsp_likelihood);
               end
            end
            stall = receiver_eager ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               stall_left = stall - 1;
            end
         end else if (!rsp_ready) begin
            if (stall_left == 0) rsp_ready <= 1'b1;
            else stall_left--;
         end
      end
   end

   initial begin
      longint             one, step, term, ratio, acc, e;
      int                 current;
      skinp_pkg::cfg_type cfg;
      cfg_kind_type       kind;
      logic [7:0]         warm_red, warm_green, warm_blue;
      logic [7:0]         c0, c1, c2;

      one = 64'sd1 <<< 31;
      step = (64'sd8 <<< 31) / skinp_pkg::EXP_TABLE_DEPTH;
      term = one;
      ratio = one;
      acc = one;
      for (int k = 1; k <= 12; k++) begin
         term = (term * step) >>> 31;
         term = term / k;
         if (k % 2 == 1) ratio = ratio - term;
         else ratio = ratio + term;
      end
      for (int i = 0; i < skinp_pkg::EXP_TABLE_DEPTH; i++) begin
         e = (255 * acc + (64'sd1 <<< 30)) >>> 31;
         if (e > 255) e = 255;
         if (e < 0) e = 0;
         exp_table[i] = 8'(e);
         acc = (acc * ratio + (64'sd1 <<< 30)) >>> 31;
      end

      directed_cfg[0] = '{skinp_pkg::RESET_MEAN_CB, skinp_pkg::RESET_MEAN_CR,
                          skinp_pkg::RESET_INV_COV_BB, skinp_pkg::RESET_INV_COV_BR,
                          skinp_pkg::RESET_INV_COV_RR, 1'b0};
      directed_cfg[1] = '{skinp_pkg::RESET_MEAN_CB, skinp_pkg::RESET_MEAN_CR,
                          16'h0000, 16'h0000, 16'h0000, 1'b0};
      directed_cfg[2] = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0};
      directed_cfg[3] = '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1};
      directed_cfg[4] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b1};

      // Typed values: zero covariance gives the top entry, a huge form saturates to zero,
      // and a negative cross term with same-sign offsets gives a negative form.
      directed_rows = '{
         '{3'd0, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
         '{3'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
         '{3'd0, 8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
         '{3'd0, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
         '{3'd0, 8'd0,   8'd0,   8'd255, 1'b0, 8'd0},
         '{3'd0, 8'd200, 8'd150, 8'd120, 1'b0, 8'd0},
         '{3'd0, 8'd224, 8'd172, 8'd138, 1'b0, 8'd0},
         '{3'd0, 8'd180, 8'd120, 8'd100, 1'b0, 8'd0},
         '{3'd0, 8'd120, 8'd120, 8'd120, 1'b0, 8'd0},
         '{3'd0, 8'd85,  8'd170, 8'd51,  1'b0, 8'd0},
         '{3'd1, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
         '{3'd1, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
         '{3'd1, 8'd37,  8'd201, 8'd142, 1'b1, 8'd255},
         '{3'd2, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
         '{3'd2, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
         '{3'd2, 8'd128, 8'd128, 8'd128, 1'b0, 8'd0},
         '{3'd3, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
         '{3'd3, 8'd0,   8'd0,   8'd0,   1'b1, 8'd255},
         '{3'd3, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
         '{3'd4, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
         '{3'd4, 8'd255, 8'd0,   8'd0,   1'b0, 8'd0},
         '{3'd4, 8'd0,   8'd0,   8'd255, 1'b0, 8'd0}
      };

      error_count = 0;
      pixels_sent = 0;
      results_seen = 0;
      settings_applied = 0;
      sender_eager = 1'b0;
      receiver_eager = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_chan_zero <= '0;
      req_chan_one <= '0;
      req_chan_two <= '0;
      row_typed <= 1'b0;
      row_want <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      current = 0;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (int'(directed_rows[r].setting) != current) begin
            current = int'(directed_rows[r].setting);
            settle();
            apply_cfg(directed_cfg[current]);
            if (current == 2) begin
               // Writes past the last register must leave the settings alone.
               @(posedge clock);
               csr_write(CSR_SPARE_LO, 16'hFFFF);
               csr_write(CSR_SPARE_HI, 16'h5A5A);
               csr_we <= 1'b0;
            end
         end
         send_pixel(directed_rows[r].chan_zero, directed_rows[r].chan_one,
                    directed_rows[r].chan_two, directed_rows[r].typed, directed_rows[r].want);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         kind = (phase < 6) ? cfg_kind_type'(phase % 2) : cfg_kind_type'(phase - 4);
         case (kind)
            CFG_NEAR_DEFAULT: begin
               cfg.mean_cb = skinp_pkg::RESET_MEAN_CB
                           + 16'($urandom_range(0, 6000)) - 16'd3000;
               cfg.mean_cr = skinp_pkg::RESET_MEAN_CR
                           + 16'($urandom_range(0, 6000)) - 16'd3000;
               cfg.inv_cov_bb = skinp_pkg::RESET_INV_COV_BB
                              + 16'($urandom_range(0, 8000)) - 16'd4000;
               cfg.inv_cov_br = skinp_pkg::RESET_INV_COV_BR
                              + 16'($urandom_range(0, 4000)) - 16'd2000;
               cfg.inv_cov_rr = skinp_pkg::RESET_INV_COV_RR
                              + 16'($urandom_range(0, 8000)) - 16'd4000;
            end
            CFG_TIGHT: begin
               cfg.mean_cb = 16'($urandom_range(16'h5000, 16'hA000));
               cfg.mean_cr = 16'($urandom_range(16'h5000, 16'hA000));
               cfg.inv_cov_bb = 16'($urandom_range(0, 3000));
               cfg.inv_cov_br = 16'($urandom_range(0, 2000)) - 16'd1000;
               cfg.inv_cov_rr = 16'($urandom_range(0, 3000));
            end
            CFG_ANY: begin
               cfg.mean_cb = 16'($urandom);
               cfg.mean_cr = 16'($urandom);
               cfg.inv_cov_bb = 16'($urandom);
               cfg.inv_cov_br = 16'($urandom);
               cfg.inv_cov_rr = 16'($urandom);
            end
            default: begin
               cfg.mean_cb = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               cfg.mean_cr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               cfg.inv_cov_bb = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               cfg.inv_cov_br = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
               cfg.inv_cov_rr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
         endcase
         cfg.blue_first = 1'($urandom_range(0, 1));
         sender_eager = ($urandom_range(0, 3) == 0);
         receiver_eager = ($urandom_range(0, 3) == 0);
         settle();
         apply_cfg(cfg);
         for (int w = 0; w < PHASE_WORDS; w++) begin
            if ($urandom_range(0, 3) != 0) begin
               warm_red = 8'($urandom_range(120, 255));
               warm_green = 8'($urandom_range(70, 210));
               warm_blue = 8'($urandom_range(50, 190));
               c1 = warm_green;
               c0 = cfg.blue_first ? warm_blue : warm_red;
               c2 = cfg.blue_first ? warm_red : warm_blue;
            end else begin
               c0 = 8'($urandom);
               c1 = 8'($urandom);
               c2 = 8'($urandom);
            end
            send_pixel(c0, c1, c2, 1'b0, 8'd0);
         end
      end

      settle();
      if (likelihood_due.size() != 0) begin
         error_count++;
         $display("%0t: %0d likelihood words missing, expected %0d, got none",
                  $time, likelihood_due.size(), likelihood_due[0]);
      end
      $display("Ran %0d pixel words under %0d register settings and checked %0d likelihoods,",
               pixels_sent, settings_applied, results_seen);
      $display("with both channel orders, zero, negative and saturating forms, and stalls.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/skinp_pkg.sv
rtl/skinp_color.sv
rtl/skinp_form.sv
rtl/skinp_expo.sv
rtl/skin_probability_ycbcr.sv
verif/skin_probability_ycbcr_test.sv
